FILE: hw/rtl/gasa_pkg.sv
// Shared types and constants for the glyph atlas shelf allocator.
package gasa_pkg;

    localparam int KEY_W   = 21;
    localparam int GLYPH_W = 8;
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int PAD_W   = 4;
    localparam int STAT_W  = 2;
    localparam int DIM_W   = 16;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [SIZE_W-1:0] RESET_SIZE = 13'd128;
    localparam logic [PAD_W-1:0]  RESET_PAD  = 4'd1;

    localparam logic [1:0] REG_INIT_W = 2'd0;
    localparam logic [1:0] REG_INIT_H = 2'd1;
    localparam logic [1:0] REG_PAD    = 2'd2;

    typedef logic [DIM_W-1:0] dim_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_TOO_LARGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
    } entry_t;

    typedef struct packed {
        logic [SIZE_W-1:0] init_w;
        logic [SIZE_W-1:0] init_h;
        logic [PAD_W-1:0]  pad;
        logic              restart;
    } cfg_t;

endpackage

FILE: hw/rtl/gasa_if.sv
// Request and response channel interfaces of the glyph atlas shelf allocator.
interface gasa_req_if
    import gasa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   code_point;
    logic [GLYPH_W-1:0] glyph_width;
    logic [GLYPH_W-1:0] glyph_height;

    modport source (output valid, output code_point, output glyph_width,
                    output glyph_height, input ready);
    modport sink   (input valid, input code_point, input glyph_width,
                    input glyph_height, output ready);
endinterface

interface gasa_rsp_if
    import gasa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              was_hit;
    logic [SIZE_W-1:0] atlas_cols;
    logic [SIZE_W-1:0] atlas_rows;
    logic [STAT_W-1:0] status;

    modport source (output valid, output pos_x, output pos_y, output was_hit,
                    output atlas_cols, output atlas_rows, output status,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input was_hit,
                    input atlas_cols, input atlas_rows, input status,
                    output ready);
endinterface

FILE: hw/rtl/gasa_cache_mem.sv
// Code point cache memory: one write port, one registered read port.
module gasa_cache_mem
    import gasa_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/gasa_cfg.sv
// APB configuration registers with a restart pulse on size writes.
module gasa_cfg
    import gasa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [SIZE_W-1:0] init_w_reg;
    logic [SIZE_W-1:0] init_h_reg;
    logic [PAD_W-1:0]  pad_reg;
    logic              restart_reg;
    logic              wr;
    logic [1:0]        idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_w_reg  <= RESET_SIZE;
            init_h_reg  <= RESET_SIZE;
            pad_reg     <= RESET_PAD;
            restart_reg <= 1'b0;
        end
        else
        begin
            restart_reg <= 1'b0;
            if (wr)
            begin
                unique case (idx)
                    REG_INIT_W:
                    begin
                        init_w_reg  <= pwdata[SIZE_W-1:0];
                        restart_reg <= 1'b1;
                    end
                    REG_INIT_H:
                    begin
                        init_h_reg  <= pwdata[SIZE_W-1:0];
                        restart_reg <= 1'b1;
                    end
                    REG_PAD:
                    begin
                        pad_reg <= pwdata[PAD_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_INIT_W: prdata = APB_DW'(init_w_reg);
            REG_INIT_H: prdata = APB_DW'(init_h_reg);
            REG_PAD:    prdata = APB_DW'(pad_reg);
            default:    prdata = '0;
        endcase
    end

    // Restart is registered alongside the written size, so the new size is visible when it rises.
    assign cfg.init_w  = init_w_reg;
    assign cfg.init_h  = init_h_reg;
    assign cfg.pad     = pad_reg;
    assign cfg.restart = restart_reg;

endmodule

FILE: hw/rtl/gasa_ctrl.sv
// Search and placement sequencer with atlas state and the response register.
module gasa_ctrl
    import gasa_pkg::*;
#(
    parameter int CACHE_DEPTH = 256,
    parameter int MAX_ATLAS   = 4096,
    parameter int AW          = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    gasa_req_if.sink          req,
    gasa_rsp_if.source        rsp,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output entry_t            mem_wdata,
    output logic [AW-1:0]     mem_raddr,
    input  entry_t            mem_rdata
);

    localparam int   CW      = $clog2(CACHE_DEPTH + 1);
    localparam dim_t MAX_DIM = DIM_W'(MAX_ATLAS);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CACHE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MISS,
        S_GROW_W,
        S_SHELF,
        S_GROW_H,
        S_CHECK,
        S_EMIT
    } state_t;

    function automatic dim_t nonzero(input logic [SIZE_W-1:0] v);
        return (v == '0) ? dim_t'(1) : dim_t'(v);
    endfunction

    state_t             state_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [GLYPH_W-1:0] gw_reg;
    logic [GLYPH_W-1:0] gh_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      count_reg;
    dim_t               cur_x_reg;
    dim_t               cur_y_reg;
    logic [GLYPH_W-1:0] shelf_reg;
    dim_t               width_reg;
    dim_t               height_reg;
    dim_t               w_reg;
    dim_t               h_reg;
    dim_t               cx_reg;
    dim_t               cy_reg;
    logic [GLYPH_W-1:0] sh_reg;
    logic [POS_W-1:0]   px_reg;
    logic [POS_W-1:0]   py_reg;
    logic               hit_reg;
    status_t            status_reg;

    logic               out_valid_reg;
    logic [POS_W-1:0]   out_px_reg;
    logic [POS_W-1:0]   out_py_reg;
    logic               out_hit_reg;
    logic [SIZE_W-1:0]  out_cols_reg;
    logic [SIZE_W-1:0]  out_rows_reg;
    status_t            out_status_reg;

    dim_t               pad_d;
    dim_t               gw_d;
    dim_t               need_w;
    dim_t               need_h;
    logic               overrun;
    logic               fits;
    logic               key_match;
    logic [CW-1:0]      next_idx;
    logic               last;
    logic               accept;
    logic               emit_ok;

    assign pad_d     = dim_t'(cfg.pad);
    assign gw_d      = dim_t'(gw_reg);
    assign need_w    = gw_d + pad_d;
    assign need_h    = cy_reg + dim_t'(gh_reg) + pad_d;
    assign overrun   = (cur_x_reg + gw_d + pad_d) > w_reg;
    assign fits      = (w_reg <= MAX_DIM) && (h_reg <= MAX_DIM);
    assign key_match = mem_rdata.key == key_reg;
    assign next_idx  = idx_reg + CW'(1);
    assign last      = next_idx == count_reg;
    assign emit_ok   = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE) && !cfg.restart;
    assign accept    = req.valid && req.ready;

    // Entry 0 is fetched on accept; each search cycle fetches the next one.
    assign mem_raddr    = (state_reg == S_IDLE) ? '0 : next_idx[AW-1:0];
    assign mem_we       = (state_reg == S_CHECK) && fits;
    assign mem_waddr    = count_reg[AW-1:0];
    assign mem_wdata.key = key_reg;
    assign mem_wdata.px  = cx_reg[POS_W-1:0];
    assign mem_wdata.py  = cy_reg[POS_W-1:0];

    assign rsp.valid      = out_valid_reg;
    assign rsp.pos_x      = out_px_reg;
    assign rsp.pos_y      = out_py_reg;
    assign rsp.was_hit    = out_hit_reg;
    assign rsp.atlas_cols = out_cols_reg;
    assign rsp.atlas_rows = out_rows_reg;
    assign rsp.status     = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            shelf_reg     <= '0;
            width_reg     <= dim_t'(RESET_SIZE);
            height_reg    <= dim_t'(RESET_SIZE);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EMIT && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg.restart)
                    begin
                        count_reg  <= '0;
                        cur_x_reg  <= '0;
                        cur_y_reg  <= '0;
                        shelf_reg  <= '0;
                        width_reg  <= nonzero(cfg.init_w);
                        height_reg <= nonzero(cfg.init_h);
                    end
                    else if (accept)
                    begin
                        key_reg    <= req.code_point;
                        gw_reg     <= req.glyph_width;
                        gh_reg     <= req.glyph_height;
                        idx_reg    <= '0;
                        hit_reg    <= 1'b0;
                        px_reg     <= '0;
                        py_reg     <= '0;
                        status_reg <= STATUS_OK;
                        state_reg  <= (count_reg == '0) ? S_MISS : S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (key_match)
                    begin
                        hit_reg   <= 1'b1;
                        px_reg    <= mem_rdata.px;
                        py_reg    <= mem_rdata.py;
                        state_reg <= S_EMIT;
                    end
                    else if (last)
                    begin
                        state_reg <= S_MISS;
                    end
                    else
                    begin
                        idx_reg <= next_idx;
                    end
                end
                S_MISS:
                begin
                    if (count_reg >= FULL_COUNT)
                    begin
                        status_reg <= STATUS_FULL;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        w_reg     <= width_reg;
                        state_reg <= S_GROW_W;
                    end
                end
                S_GROW_W:
                begin
                    // Double once per cycle; stop once wide enough or past the maximum.
                    if (w_reg < need_w && w_reg <= MAX_DIM)
                    begin
                        w_reg <= w_reg << 1;
                    end
                    else
                    begin
                        state_reg <= S_SHELF;
                    end
                end
                S_SHELF:
                begin
                    if (overrun)
                    begin
                        cx_reg <= pad_d;
                        cy_reg <= cur_y_reg + dim_t'(shelf_reg) + pad_d;
                        sh_reg <= '0;
                    end
                    else
                    begin
                        cx_reg <= cur_x_reg;
                        cy_reg <= cur_y_reg;
                        sh_reg <= shelf_reg;
                    end
                    h_reg     <= height_reg;
                    state_reg <= S_GROW_H;
                end
                S_GROW_H:
                begin
                    if (h_reg < need_h && h_reg <= MAX_DIM)
                    begin
                        h_reg <= h_reg << 1;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (fits)
                    begin
                        px_reg     <= cx_reg[POS_W-1:0];
                        py_reg     <= cy_reg[POS_W-1:0];
                        width_reg  <= w_reg;
                        height_reg <= h_reg;
                        cur_x_reg  <= cx_reg + gw_d + pad_d;
                        cur_y_reg  <= cy_reg;
                        shelf_reg  <= (gh_reg > sh_reg) ? gh_reg : sh_reg;
                        count_reg  <= count_reg + CW'(1);
                    end
                    else
                    begin
                        status_reg <= STATUS_TOO_LARGE;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_px_reg     <= px_reg;
                        out_py_reg     <= py_reg;
                        out_hit_reg    <= hit_reg;
                        out_cols_reg   <= width_reg[SIZE_W-1:0];
                        out_rows_reg   <= height_reg[SIZE_W-1:0];
                        out_status_reg <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/glyph_atlas_shelf_allocator.sv
// Top level of the glyph atlas shelf allocator.
//
// Usage: send one beat on req (code_point, glyph_width, glyph_height) per
// glyph lookup; exactly one beat comes back on rsp with the glyph position,
// the hit flag, the atlas size after the request and a status code
// (ok, cache full, atlas would exceed MAX_ATLAS).
// The cache is searched linearly through the memory's one read port, one
// entry per cycle, so a hit answers sooner the nearer the front its entry
// sits; a miss first searches every cached entry, then doubles width or
// height as needed. One request is worked on at a time.
// The response sits in an output register: a stalled receiver holds the
// beat there while the next request is already being searched; the block
// only waits, with the next result ready, for the register to drain.
// Reset and any write to initial_width or initial_height while idle restart the
// atlas: cursors, shelf and cache count clear at once, and the memory needs
// no clearing pass since only entries below the count are ever read.
// Padding writes apply to the next miss. Write registers only while idle.
module glyph_atlas_shelf_allocator
    import gasa_pkg::*;
#(
    parameter int CACHE_DEPTH = 256,
    parameter int MAX_ATLAS   = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    gasa_req_if.sink          req,
    gasa_rsp_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

    cfg_t          cfg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    // Register file; size writes raise a one-cycle restart toward control.
    gasa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: search, grow width, pick shelf, grow height, commit, respond.
    gasa_ctrl #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .MAX_ATLAS   (MAX_ATLAS),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Cache entries: key and placed position, written on a successful miss.
    gasa_cache_mem #(
        .DEPTH (CACHE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

FILE: test/tb_glyph_atlas_shelf_allocator.sv
// Self-checking testbench for the glyph atlas shelf allocator.
module tb_glyph_atlas_shelf_allocator;
    import gasa_pkg::*;

    localparam int CACHE_DEPTH     = 256;
    localparam int MAX_ATLAS       = 4096;
    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int SETTLE_CYCLES   = 4;
    // a miss searches every cached entry before it answers
    localparam int DRAIN_CYCLES    = CACHE_DEPTH + 40;

    // no register sits at this index; writes to it must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // one response beat as the block should return it
    typedef struct packed {
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic              hit;
        logic [SIZE_W-1:0] cols;
        logic [SIZE_W-1:0] rows;
        status_t           status;
    } glyph_slot_t;

    typedef enum logic {ROW_GLYPH, ROW_WRITE} row_kind_t;

    // one line of the directed script: a lookup or a register write
    typedef struct packed {
        row_kind_t          kind;
        logic [1:0]         reg_idx;
        logic [31:0]        wdata;
        logic [KEY_W-1:0]   key;
        logic [GLYPH_W-1:0] gw;
        logic [GLYPH_W-1:0] gh;
        logic               typed;
        glyph_slot_t        want;
    } script_row_t;

    // shape of the random glyph traffic in a phase
    typedef enum logic [1:0] {MIX_GENERAL, MIX_TALL, MIX_DENSE} glyph_mix_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    gasa_req_if req();
    gasa_rsp_if rsp();

    glyph_atlas_shelf_allocator #(
        .CACHE_DEPTH(CACHE_DEPTH),
        .MAX_ATLAS  (MAX_ATLAS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // Shadow copy of the allocator: configuration, packing cursors and the cache.
    int unsigned cfg_w;
    int unsigned cfg_h;
    int unsigned cfg_pad;
    int unsigned cur_x;
    int unsigned cur_y;
    int unsigned shelf_h;
    int unsigned atlas_w;
    int unsigned atlas_h;
    int unsigned placed;
    logic [KEY_W-1:0] cached_key [CACHE_DEPTH];
    logic [POS_W-1:0] cached_px  [CACHE_DEPTH];
    logic [POS_W-1:0] cached_py  [CACHE_DEPTH];

    // Response beats still owed by the block, oldest first.
    glyph_slot_t awaited_placements [$];

    // Knobs for the idle behavior of both sides.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_off_pending   = 1'b0;

    int errors      = 0;
    int n_hits      = 0;
    int n_placed    = 0;
    int n_full      = 0;
    int n_oversize  = 0;
    int n_writes    = 0;

    // Double a dimension until it covers need; stop once past the atlas limit.
    function automatic int unsigned doubled_to(int unsigned d, int unsigned need);
        int unsigned g;
        g = d;
        while (g < need && g <= MAX_ATLAS)
            g = g << 1;
        return g;
    endfunction

    // Reload the atlas size and forget every placement.
    function automatic void restart_atlas();
        cur_x   = 0;
        cur_y   = 0;
        shelf_h = 0;
        atlas_w = (cfg_w == 0) ? 1 : cfg_w;
        atlas_h = (cfg_h == 0) ? 1 : cfg_h;
        placed  = 0;
    endfunction

    function automatic void latch_register(logic [1:0] idx, logic [31:0] v);
        case (idx)
            REG_INIT_W:
            begin
                cfg_w = v[SIZE_W-1:0];
                restart_atlas();
            end
            REG_INIT_H:
            begin
                cfg_h = v[SIZE_W-1:0];
                restart_atlas();
            end
            REG_PAD: cfg_pad = v[PAD_W-1:0];
            default: ;
        endcase
    endfunction

    // Look a glyph up and, on a miss, pack it onto the current or a new shelf.
    function automatic glyph_slot_t place_glyph(logic [KEY_W-1:0] key,
                                                logic [GLYPH_W-1:0] gw,
                                                logic [GLYPH_W-1:0] gh);
        glyph_slot_t slot;
        int unsigned gwi;
        int unsigned ghi;
        int unsigned w;
        int unsigned h;
        int unsigned cx;
        int unsigned cy;
        int unsigned sh;
        bit          found;
        slot   = '0;
        slot.status = STATUS_OK;
        found  = 1'b0;
        gwi    = gw;
        ghi    = gh;
        for (int unsigned i = 0; i < placed; i++)
        begin
            if (!found && cached_key[i] == key)
            begin
                found    = 1'b1;
                slot.hit = 1'b1;
                slot.px  = cached_px[i];
                slot.py  = cached_py[i];
            end
        end
        if (!found)
        begin
            if (placed >= CACHE_DEPTH)
            begin
                slot.status = STATUS_FULL;
            end
            else
            begin
                w  = doubled_to(atlas_w, gwi + cfg_pad);
                cx = cur_x;
                cy = cur_y;
                sh = shelf_h;
                // on an overrun, open a new shelf below the tallest glyph of the current shelf
                if (cx + gwi + cfg_pad > w)
                begin
                    cy = cy + sh + cfg_pad;
                    cx = cfg_pad;
                    sh = 0;
                end
                h = doubled_to(atlas_h, cy + ghi + cfg_pad);
                if (w > MAX_ATLAS || h > MAX_ATLAS)
                begin
                    slot.status = STATUS_TOO_LARGE;
                end
                else
                begin
                    slot.px            = cx[POS_W-1:0];
                    slot.py            = cy[POS_W-1:0];
                    atlas_w            = w;
                    atlas_h            = h;
                    cur_x              = cx + gwi + cfg_pad;
                    cur_y              = cy;
                    shelf_h            = (ghi > sh) ? ghi : sh;
                    cached_key[placed] = key;
                    cached_px[placed]  = cx[POS_W-1:0];
                    cached_py[placed]  = cy[POS_W-1:0];
                    placed++;
                end
            end
        end
        slot.cols = atlas_w[SIZE_W-1:0];
        slot.rows = atlas_h[SIZE_W-1:0];
        return slot;
    endfunction

    function automatic script_row_t glyph_row(logic [KEY_W-1:0] key,
                                              logic [GLYPH_W-1:0] gw,
                                              logic [GLYPH_W-1:0] gh);
        script_row_t r;
        r      = '0;
        r.kind = ROW_GLYPH;
        r.key  = key;
        r.gw   = gw;
        r.gh   = gh;
        return r;
    endfunction

    // Lookup whose answer is written out by hand.
    function automatic script_row_t fixed_row(logic [KEY_W-1:0] key,
                                              logic [GLYPH_W-1:0] gw,
                                              logic [GLYPH_W-1:0] gh,
                                              logic [POS_W-1:0] px,
                                              logic [POS_W-1:0] py,
                                              logic hit,
                                              logic [SIZE_W-1:0] cols,
                                              logic [SIZE_W-1:0] rows,
                                              status_t status);
        script_row_t r;
        r             = glyph_row(key, gw, gh);
        r.typed       = 1'b1;
        r.want.px     = px;
        r.want.py     = py;
        r.want.hit    = hit;
        r.want.cols   = cols;
        r.want.rows   = rows;
        r.want.status = status;
        return r;
    endfunction

    function automatic script_row_t write_row(logic [1:0] idx, logic [31:0] v);
        script_row_t r;
        r         = '0;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.wdata   = v;
        return r;
    endfunction

    function automatic void check_field(string field_name, logic [15:0] want_v,
                                        logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s expected %0d got %0d", field_name, want_v, got_v);
            errors++;
        end
    endfunction

    // Offer one request beat, with random idle cycles ahead of it; predict on accept.
    task automatic send_glyph(logic [KEY_W-1:0] key, logic [GLYPH_W-1:0] gw,
                              logic [GLYPH_W-1:0] gh, logic typed, glyph_slot_t want);
        glyph_slot_t got;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid        = 1'b1;
        req.code_point   = key;
        req.glyph_width  = gw;
        req.glyph_height = gh;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        got = place_glyph(key, gw, gh);
        if (got.hit)
            n_hits++;
        else if (got.status == STATUS_FULL)
            n_full++;
        else if (got.status == STATUS_TOO_LARGE)
            n_oversize++;
        else
            n_placed++;
        awaited_placements.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed beat has come back.
    task automatic settle(int extra);
        req.valid = 1'b0;
        while (awaited_placements.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // APB write, then read the register back unless the index has none.
    task automatic write_register(logic [1:0] idx, logic [31:0] v);
        logic [31:0] mask;
        paddr   = {idx, 2'b00};
        pwdata  = v;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        latch_register(idx, v);
        n_writes++;
        @(negedge clk);
        if (idx != REG_UNUSED)
        begin
            pwrite  = 1'b0;
            penable = 1'b0;
            @(negedge clk);
            penable = 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            mask = (idx == REG_PAD) ? 32'h0000_000F : 32'h0000_1FFF;
            if (prdata !== (v & mask))
            begin
                $error("prdata expected %0d got %0d", v & mask, prdata);
                errors++;
            end
            @(negedge clk);
        end
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Program a fresh atlas, set the idle knobs, then stream random lookups.
    task automatic run_phase(glyph_mix_t mix, int count, int sender_pct, int receiver_pct,
                             logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                             logic [PAD_W-1:0] pad, bit squeeze);
        logic [KEY_W-1:0]   key;
        logic [GLYPH_W-1:0] gw;
        logic [GLYPH_W-1:0] gh;
        int                 reuse_pct;
        settle(SETTLE_CYCLES);
        write_register(REG_INIT_W, 32'(w));
        write_register(REG_INIT_H, 32'(h));
        write_register(REG_PAD, 32'(pad));
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
        if (squeeze)
            hold_off_pending = 1'b1;
        repeat (count)
        begin
            case (mix)
                MIX_TALL:  reuse_pct = 20;
                MIX_DENSE: reuse_pct = (placed < CACHE_DEPTH) ? 10 : 50;
                default:   reuse_pct = 40;
            endcase
            key = $urandom_range(0, (1 << KEY_W) - 1);
            if (placed != 0 && $urandom_range(0, 99) < reuse_pct)
                key = cached_key[$urandom_range(0, placed - 1)];
            case (mix)
                MIX_TALL:
                begin
                    // roughly one glyph per shelf, so the height runs out
                    gw = $urandom_range(180, 255);
                    gh = $urandom_range(180, 255);
                end
                MIX_DENSE:
                begin
                    // tiny glyphs: the cache fills long before the atlas does
                    gw = $urandom_range(0, 15);
                    gh = $urandom_range(0, 15);
                end
                default:
                begin
                    if ($urandom_range(0, 99) < 70)
                    begin
                        gw = $urandom_range(0, 40);
                        gh = $urandom_range(0, 40);
                    end
                    else
                    begin
                        gw = $urandom_range(0, 255);
                        gh = $urandom_range(0, 255);
                    end
                end
            endcase
            send_glyph(key, gw, gh, 1'b0, '0);
        end
    endtask

    // Receiver: random stalls, or one long hold-off when asked for.
    initial
    begin : receiver
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_pending)
            begin
                // hold ready low long enough that the request side backs up
                hold_off_pending = 1'b0;
                rsp.ready        = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                rsp.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // Compare every accepted response beat with the oldest prediction.
    always @(posedge clk)
    begin : check_beat
        glyph_slot_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (awaited_placements.size() == 0)
            begin
                $error("response beat with no request outstanding");
                errors++;
            end
            else
            begin
                want = awaited_placements.pop_front();
                check_field("pos_x", 16'(want.px), 16'(rsp.pos_x));
                check_field("pos_y", 16'(want.py), 16'(rsp.pos_y));
                check_field("was_hit", 16'(want.hit), 16'(rsp.was_hit));
                check_field("atlas_cols", 16'(want.cols), 16'(rsp.atlas_cols));
                check_field("atlas_rows", 16'(want.rows), 16'(rsp.atlas_rows));
                check_field("status", 16'(want.status), 16'(rsp.status));
            end
        end
    end

    // Watchdog: give up once nothing has moved on any port for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
                || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        script_row_t script [26];

        // drive every input to a known value and hold reset
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req.valid        = 1'b0;
        req.code_point   = '0;
        req.glyph_width  = '0;
        req.glyph_height = '0;

        cfg_w   = RESET_SIZE;
        cfg_h   = RESET_SIZE;
        cfg_pad = RESET_PAD;
        restart_atlas();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed script. Hand-written answers cover the first placement after
        // reset, a plain hit, and the oversize refusals; the rest is predicted.
        script = '{
            fixed_row(21'h000000, 8'd0, 8'd0, 12'd0, 12'd0, 1'b0, 13'd128, 13'd128,
                      STATUS_OK),
            fixed_row(21'h000000, 8'd255, 8'd255, 12'd0, 12'd0, 1'b1, 13'd128, 13'd128,
                      STATUS_OK),
            // widest glyph: width doubles, then the glyph opens a new shelf
            glyph_row(21'h1FFFFF, 8'd255, 8'd255),
            glyph_row(21'h155555, 8'hAA, 8'h55),
            glyph_row(21'h0AAAAA, 8'h55, 8'hAA),
            glyph_row(21'h1FFFFF, 8'd0, 8'd0),
            // widest padding applies to the next miss and keeps the cache
            write_row(REG_PAD, 32'd15),
            glyph_row(21'h10FFFF, 8'd200, 8'd10),
            glyph_row(21'h155555, 8'd0, 8'd0),
            // write to an index with no register behind it
            write_row(REG_UNUSED, 32'hFFFF_FFFF),
            glyph_row(21'h0AAAAA, 8'd1, 8'd1),
            // zero width register counts as one pixel and clears the atlas
            write_row(REG_INIT_W, 32'd0),
            glyph_row(21'h000001, 8'd0, 8'd0),
            glyph_row(21'h000000, 8'd0, 8'd0),
            write_row(REG_INIT_H, 32'd0),
            glyph_row(21'h000007, 8'd0, 8'd0),
            // configured height beyond the limit refuses every miss
            write_row(REG_INIT_H, 32'd8191),
            fixed_row(21'h000003, 8'd1, 8'd1, 12'd0, 12'd0, 1'b0, 13'd1, 13'd8191,
                      STATUS_TOO_LARGE),
            write_row(REG_INIT_H, 32'd4096),
            write_row(REG_INIT_W, 32'd8191),
            fixed_row(21'h000003, 8'd1, 8'd1, 12'd0, 12'd0, 1'b0, 13'd8191, 13'd4096,
                      STATUS_TOO_LARGE),
            // largest legal atlas with no padding
            write_row(REG_INIT_W, 32'd4096),
            write_row(REG_PAD, 32'd0),
            glyph_row(21'h000005, 8'd255, 8'd255),
            glyph_row(21'h000006, 8'd255, 8'd255),
            glyph_row(21'h000005, 8'd0, 8'd0)
        };

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                settle(SETTLE_CYCLES);
                write_register(script[i].reg_idx, script[i].wdata);
            end
            else
            begin
                send_glyph(script[i].key, script[i].gw, script[i].gh, script[i].typed,
                           script[i].want);
            end
        end

        // Random phases: back to back, a sender with gaps, a slow receiver while
        // the cache fills up, both sides idling, and a long receiver hold-off.
        run_phase(MIX_GENERAL, 80, 0, 0, 13'd128, 13'd128, 4'd1, 1'b0);
        run_phase(MIX_TALL, 60, 49, 0, 13'd256, 13'd2048, 4'd1, 1'b0);
        run_phase(MIX_DENSE, 320, 0, 49, 13'd4096, 13'd4096, 4'($urandom_range(0, 15)),
                  1'b0);
        run_phase(MIX_GENERAL, 70, 36, 36, 13'd1, 13'd1, 4'd15, 1'b0);
        run_phase(MIX_GENERAL, 70, 0, 0, 13'd128, 13'd128, 4'($urandom_range(0, 15)),
                  1'b1);

        // drain, then watch for stray beats
        settle(DRAIN_CYCLES);

        $display("lookups: %0d hits, %0d placed, %0d refused as cache full, %0d as oversize",
                 n_hits, n_placed, n_full, n_oversize);
        $display("register writes: %0d, over idle, stall and hold-off patterns", n_writes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/gasa_pkg.sv
hw/rtl/gasa_if.sv
hw/rtl/gasa_cache_mem.sv
hw/rtl/gasa_cfg.sv
hw/rtl/gasa_ctrl.sv
hw/rtl/glyph_atlas_shelf_allocator.sv
test/tb_glyph_atlas_shelf_allocator.sv
